// File: src/rice_code_packer_macros.svh
// ----------------------------------------------------------------------------
// Rice code packer assertion macros
// Clocked assertion helpers shared by the packer RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RICE_CODE_PACKER_MACROS_SVH
`define RICE_CODE_PACKER_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define RCP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Implication checked in the same cycle.
`define RCP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define RCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RCP_ASSERT_ALWAYS(label, cond, msg)
`define RCP_ASSERT_SAME(label, ante, cons, msg)
`define RCP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: src/rcp_pkg.sv
// ----------------------------------------------------------------------------
// Rice code packer package
// Shared constants, payload types and control bundles of the packer.
// ----------------------------------------------------------------------------
package rcp_pkg;

    localparam int unsigned SampleWidth = 16;
    localparam int unsigned WordBits    = 32;
    localparam int unsigned CountWidth  = 16;
    localparam int unsigned KWidth      = 4;
    localparam int unsigned CodeWidth   = 17;
    localparam int unsigned LenWidth    = 5;
    localparam int unsigned EscLimit    = 8;
    localparam int unsigned EscLen      = 25;
    localparam int unsigned QueueDepthDefault = 4;

    localparam logic [KWidth-1:0]     RiceKReset = 4'd3;
    localparam logic [CountWidth-1:0] CountMax   = 16'hFFFF;

    typedef struct packed {
        logic signed [SampleWidth-1:0] sample;
        logic                          block_end;
    } sample_in_t;

    typedef struct packed {
        logic [WordBits-1:0]   word;
        logic                  word_last;
        logic [CountWidth-1:0] word_count;
    } word_out_t;

    // One sample's code, right-aligned, with its length in bits.
    typedef struct packed {
        logic [CodeWidth-1:0] code;
        logic [LenWidth-1:0]  clen;
    } rice_code_t;

    // Up to two words written into the output queue in one cycle.
    typedef struct packed {
        logic [1:0] cnt;
        word_out_t  first;
        word_out_t  second;
    } word_push_t;

endpackage

// File: src/rcp_coder.sv
// ----------------------------------------------------------------------------
// Rice coder
// Saturates one sample and forms its Rice code or escape code with length.
// ----------------------------------------------------------------------------
module rcp_coder
(
    input  logic [rcp_pkg::KWidth-1:0]             rice_k,
    input  logic signed [rcp_pkg::SampleWidth-1:0] sample,
    output rcp_pkg::rice_code_t                    code_out
);

    logic signed [15:0] sat;
    logic [15:0]        neg_val;
    logic               neg;
    logic [14:0]        mag;
    logic [14:0]        quo;
    logic [14:0]        rem_mask;
    logic [14:0]        rem;
    logic               esc;

    always_comb
    begin
        // The most negative sample has no positive twin, so it is pulled in by one.
        sat      = (sample == 16'sh8000) ? 16'sh8001 : sample;
        neg      = sat[15];
        neg_val  = 16'(-sat);
        mag      = neg ? neg_val[14:0] : sat[14:0];
        quo      = mag >> rice_k;
        rem_mask = ~(15'h7FFF << rice_k);
        rem      = mag & rem_mask;
        esc      = (quo >= 15'(rcp_pkg::EscLimit));

        if (esc)
        begin
            // The leading zeros are implied by the length.
            code_out.code = {1'b1, 1'b0, sat[14:0]};
            code_out.clen = rcp_pkg::LenWidth'(rcp_pkg::EscLen);
        end
        else
        begin
            code_out.code = ({15'd0, 1'b1, neg} << rice_k) | {2'b00, rem};
            code_out.clen = quo[4:0] + 5'd2 + {1'b0, rice_k};
        end
    end

endmodule

// File: src/rcp_out_queue.sv
// ----------------------------------------------------------------------------
// Output word queue
// Small register queue that takes up to two words a cycle and sends one unless stalled.
// ----------------------------------------------------------------------------
module rcp_out_queue
#(
    parameter int unsigned Depth = rcp_pkg::QueueDepthDefault
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rcp_pkg::word_push_t    push,
    output logic                   room,
    output logic [$clog2(Depth+1)-1:0] level,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rcp_pkg::word_out_t     out_data
);

    localparam int unsigned IdxW = $clog2(Depth);
    localparam int unsigned LvlW = $clog2(Depth + 1);

    rcp_pkg::word_out_t entry_reg [Depth];

    logic [IdxW-1:0] head_reg;
    logic [IdxW-1:0] head_next;
    logic [IdxW-1:0] tail_reg;
    logic [IdxW-1:0] tail_next;
    logic [IdxW-1:0] tail_plus1;
    logic [LvlW-1:0] level_reg;
    logic [LvlW-1:0] level_next;
    logic            pop;

    function automatic logic [IdxW-1:0] ptr_inc(input logic [IdxW-1:0] ptr);
        logic [IdxW-1:0] nxt;
        nxt = (ptr == IdxW'(Depth - 1)) ? '0 : ptr + 1'b1;
        return nxt;
    endfunction

    always_comb
    begin
        pop        = (level_reg != '0) && !out_stall;
        tail_plus1 = ptr_inc(tail_reg);
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        case (push.cnt)
            2'd1:    tail_next = tail_plus1;
            2'd2:    tail_next = ptr_inc(tail_plus1);
            default: tail_next = tail_reg;
        endcase
        level_next = level_reg + LvlW'(push.cnt) - LvlW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entry_reg[tail_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            entry_reg[tail_plus1] <= push.second;
        end
    end

    // Two free slots are needed, since one sample can finish two words.
    assign room      = (level_reg <= LvlW'(Depth - 2));
    assign level     = level_reg;
    assign out_valid = (level_reg != '0);
    assign out_data  = entry_reg[head_reg];

endmodule

// File: src/rice_code_packer.sv
// ----------------------------------------------------------------------------
// Rice code packer
// Rice-codes signed samples and packs the codes MSB-first into 32-bit words.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  input     in_valid / in_stall       in_data  (sample, block_end)
//  output    out_valid / out_stall     out_data (word, word_last, word_count)
//  config    cfg_wr_en                 cfg_wr_data (rice_k)
//
//  One sample per cycle while the queue has room: a sample is held in the
//  input register, then coded and merged with the pending bits, and its
//  words are registered in a small output queue, from which they leave.
//  The input stalls only while the queue has fewer than two free slots.
//  Reset clears the pending bits, the word count and the queue, and sets
//  rice_k to 3.
// ----------------------------------------------------------------------------
`include "rice_code_packer_macros.svh"

module rice_code_packer
#(
    parameter int unsigned QueueDepth = rcp_pkg::QueueDepthDefault
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rcp_pkg::KWidth-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  rcp_pkg::sample_in_t        in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output rcp_pkg::word_out_t         out_data
);

    logic [rcp_pkg::KWidth-1:0]     rice_k_reg;
    logic                           in_vld_reg;
    logic                           in_vld_next;
    rcp_pkg::sample_in_t            in_reg;
    logic [30:0]                    pend_reg;
    logic [30:0]                    pend_next;
    logic [4:0]                     pend_len_reg;
    logic [4:0]                     pend_len_next;
    logic [rcp_pkg::CountWidth-1:0] words_reg;
    logic [rcp_pkg::CountWidth-1:0] words_next;

    rcp_pkg::rice_code_t            cw;
    rcp_pkg::word_push_t            push;
    logic                           room;
    logic [$clog2(QueueDepth+1)-1:0] q_level;
    logic                           accept;
    logic                           proc;

    logic [55:0]                    acc;
    logic [55:0]                    rem_mask;
    logic [55:0]                    acc_masked;
    logic [5:0]                     len;
    logic                           full;
    logic [4:0]                     rem_len;
    logic [30:0]                    rem;
    logic [31:0]                    w_full;
    logic [31:0]                    w_flush;
    logic                           do_flush;
    logic [rcp_pkg::CountWidth-1:0] cnt1;
    logic [rcp_pkg::CountWidth-1:0] cnt2;

    rcp_coder u_coder
    (
        .rice_k   (rice_k_reg),
        .sample   (in_reg.sample),
        .code_out (cw)
    );

    rcp_out_queue
    #(
        .Depth (QueueDepth)
    )
    u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .level     (q_level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign proc     = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = accept ? 1'b1 : (proc ? 1'b0 : in_vld_reg);

        acc  = ({25'd0, pend_reg} << cw.clen) | {39'd0, cw.code};
        len  = {1'b0, pend_len_reg} + {1'b0, cw.clen};
        full = len[5];
        // Below a full word the bit count is the length itself; above it,
        // the low five bits are what is left after the word.
        rem_len    = len[4:0];
        w_full     = 32'(acc >> rem_len);
        rem_mask   = ~(56'hFF_FFFF_FFFF_FFFF << rem_len);
        acc_masked = acc & rem_mask;
        rem        = full ? acc_masked[30:0] : acc[30:0];
        w_flush    = 32'({1'b0, rem} << (6'd32 - {1'b0, rem_len}));
        do_flush   = in_reg.block_end && (rem_len != 5'd0);

        cnt1 = (words_reg == rcp_pkg::CountMax) ? words_reg : words_reg + 1'b1;
        cnt2 = (cnt1 == rcp_pkg::CountMax) ? cnt1 : cnt1 + 1'b1;

        push.cnt               = proc ? ({1'b0, full} + {1'b0, do_flush}) : 2'd0;
        push.first.word        = full ? w_full : w_flush;
        push.first.word_last   = full ? (in_reg.block_end && (rem_len == 5'd0)) : 1'b1;
        push.first.word_count  = cnt1;
        push.second.word       = w_flush;
        push.second.word_last  = 1'b1;
        push.second.word_count = cnt2;

        pend_next     = pend_reg;
        pend_len_next = pend_len_reg;
        words_next    = words_reg;
        if (proc)
        begin
            if (in_reg.block_end)
            begin
                pend_next     = '0;
                pend_len_next = '0;
                words_next    = '0;
            end
            else
            begin
                pend_next     = rem;
                pend_len_next = rem_len;
                words_next    = full ? cnt1 : words_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rice_k_reg   <= rcp_pkg::RiceKReset;
            in_vld_reg   <= 1'b0;
            pend_reg     <= '0;
            pend_len_reg <= '0;
            words_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rice_k_reg <= cfg_wr_data;
            end
            in_vld_reg   <= in_vld_next;
            pend_reg     <= pend_next;
            pend_len_reg <= pend_len_next;
            words_reg    <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
    end

    `RCP_ASSERT_SAME(a_end_emits_word, proc && in_reg.block_end, push.cnt != 2'd0, "block end produced no word")
    `RCP_ASSERT_NEXT(a_end_clears_state, proc && in_reg.block_end, (pend_len_reg == 5'd0) && (words_reg == '0), "state not cleared after block end")
    `RCP_ASSERT_ALWAYS(a_queue_bound, q_level <= ($clog2(QueueDepth+1))'(QueueDepth), "output queue overfilled")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rice code packer testbench
// Feeds signed samples through the packer under several rice_k settings, with
// random sender gaps and receiver stalls. The bench computes the packed words
// itself and checks every output word against them, field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CycleLimit   = 500000;
    localparam int unsigned SettleCycles = 8;
    localparam int unsigned PhaseCount   = 8;
    localparam int unsigned PhaseSamples = 80;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [rcp_pkg::KWidth-1:0] cfg_wr_data = '0;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    rcp_pkg::sample_in_t        in_data     = '0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    rcp_pkg::word_out_t         out_data;

    // Bench copy of the coder state.
    logic [rcp_pkg::KWidth-1:0]     coder_k        = rcp_pkg::RiceKReset;
    logic [30:0]                    held_bits      = '0;
    logic [rcp_pkg::LenWidth-1:0]   held_len       = '0;
    logic [rcp_pkg::CountWidth-1:0] waveform_words = '0;

    rcp_pkg::word_out_t   expected_words[$];
    rcp_pkg::sample_in_t  sample_queue[$];
    int unsigned samples_queued = 0;
    int unsigned samples_taken  = 0;
    int unsigned fail_cnt       = 0;
    int unsigned cycle_cnt      = 0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    bit          send_gaps_on   = 1'b1;
    bit          stall_gaps_on  = 1'b1;

    rice_code_packer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic emit_word(input logic [31:0] bits, input logic last);
        rcp_pkg::word_out_t w;
        if (waveform_words != rcp_pkg::CountMax)
            waveform_words++;
        w.word       = bits;
        w.word_last  = last;
        w.word_count = waveform_words;
        expected_words.push_back(w);
    endtask

    task automatic pack_sample(input rcp_pkg::sample_in_t s);
        int          value;
        int unsigned mag;
        int unsigned quo;
        int unsigned clen;
        int unsigned len;
        logic        neg;
        logic [63:0] acc;
        logic [63:0] code;
        logic [63:0] aligned;
        value = $signed(s.sample);
        if (value < -32767)
            value = -32767;
        neg = (value < 0);
        mag = neg ? -value : value;
        quo = mag >> coder_k;
        if (quo < rcp_pkg::EscLimit)
        begin
            code = ((64'd2 | 64'(neg)) << coder_k) | 64'(mag & ((32'd1 << coder_k) - 1));
            clen = quo + 2 + coder_k;
        end
        else
        begin
            // Escape: the field keeps the low 15 bits of the saturated sample.
            code = (64'd1 << 16) | 64'(value & 32'h7FFF);
            clen = rcp_pkg::EscLen;
        end
        acc = (64'(held_bits) << clen) | code;
        len = held_len + clen;
        if (len >= rcp_pkg::WordBits)
        begin
            len = len - rcp_pkg::WordBits;
            emit_word(acc[len +: 32], s.block_end && (len == 0));
            acc = acc & ((64'd1 << len) - 1);
        end
        if (s.block_end && (len != 0))
        begin
            aligned = acc << (rcp_pkg::WordBits - len);
            emit_word(aligned[31:0], 1'b1);
            acc = '0;
            len = 0;
        end
        held_bits = acc[30:0];
        held_len  = len[rcp_pkg::LenWidth-1:0];
        if (s.block_end)
            waveform_words = '0;
    endtask

    function automatic int draw_value(input int unsigned k);
        int unsigned span;
        int          value;
        span = (10 << k) - 1;
        if (span > 32767)
            span = 32767;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? -32768 : 32767;
            1, 2, 3: value = $urandom_range(0, 32767);
            default: value = $urandom_range(0, span);
        endcase
        return $urandom_range(0, 1) ? -value : value;
    endfunction

    task automatic queue_sample(input int value, input logic last);
        rcp_pkg::sample_in_t s;
        s.sample    = value[15:0];
        s.block_end = last;
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    // Returns once every queued sample is taken, every word has arrived and
    // the input register has had time to empty.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (samples_taken != samples_queued || expected_words.size() != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_rice_k(input logic [rcp_pkg::KWidth-1:0] k);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        coder_k = k;
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : sample_driver
        logic busy;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                pack_sample(in_data);
                samples_taken++;
                busy = 1'b0;
                send_gap = send_gaps_on ? $urandom_range(0, 3) : 0;
            end
            if (!busy)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    in_data  <= sample_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : word_monitor
        rcp_pkg::word_out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: unexpected word, expected none, actual %h", $time,
                             out_data);
                end
                else
                begin
                    want = expected_words.pop_front();
                    compare_field("word", want.word, out_data.word);
                    compare_field("word_last", 32'(want.word_last), 32'(out_data.word_last));
                    compare_field("word_count", 32'(want.word_count),
                                  32'(out_data.word_count));
                end
                stall_left = stall_gaps_on ? $urandom_range(0, 3) : 0;
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [rcp_pkg::KWidth-1:0] k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at the reset value of rice_k. The first two fill
        // exactly one word and end the waveform on the word boundary.
        queue_sample(64, 1'b0);
        queue_sample(16, 1'b1);
        queue_sample(0, 1'b0);
        queue_sample(1, 1'b0);
        queue_sample(-1, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(-32767, 1'b0);
        queue_sample(7, 1'b0);
        queue_sample(-7, 1'b0);
        queue_sample(63, 1'b0);
        queue_sample(-63, 1'b0);
        queue_sample(64, 1'b0);
        queue_sample(-64, 1'b0);
        queue_sample(21845, 1'b0);
        queue_sample(-21846, 1'b0);
        queue_sample(5, 1'b1);
        queue_sample(0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            case (ph)
                0: k = '0;
                1: k = '1;
                2: k = rcp_pkg::RiceKReset;
                default: k = rcp_pkg::KWidth'($urandom_range(0, 15));
            endcase
            send_gaps_on  = (ph % 2 == 0);
            stall_gaps_on = (ph % 3 != 1);
            write_rice_k(k);
            for (int i = 0; i < PhaseSamples; i++)
                queue_sample(draw_value(k), $urandom_range(0, 11) == 0);
            wait_drained();
        end

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: rice_code_packer.f
+incdir+src
src/rcp_pkg.sv
src/rcp_coder.sv
src/rcp_out_queue.sv
src/rice_code_packer.sv
tb/tb_top.sv
